>>> hw/rtl/cpr_pkg.sv
// Shared types, constants and helper functions for the clock page replacement core.
// Depends on nothing; cpr_engine, the top level and cpr_checker import it.
`timescale 1ns / 1ps

package cpr_pkg;

  // Table geometry.
  localparam int unsigned FRAMES    = 8;
  localparam int unsigned FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W     = $clog2(FRAMES + 1);
  localparam int unsigned PAGE_W    = 12;
  localparam int unsigned FCNT_W    = 16;
  localparam int unsigned OFRAME_W  = 3;
  localparam int unsigned FIU_W     = 4;
  localparam int unsigned WA_W      = 8;

  // Configuration port.
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE  = CFG_IDX_W'(2);

  localparam logic [FIU_W-1:0]  FIU_RESET = FIU_W'(8);
  localparam logic [FCNT_W-1:0] FCNT_MAX  = '1;

  // Replacement policies.
  localparam logic MODE_BASIC    = 1'b0;
  localparam logic MODE_ENHANCED = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_HIT,
    S_FILL,
    S_CLEAR,
    S_SCAN,
    S_EVRD,
    S_LOAD
  } cpr_state_e;

  // One input item.
  typedef struct packed {
    logic              action;
    logic [PAGE_W-1:0] page;
    logic              is_write;
  } cpr_in_t;

  // One result item.
  typedef struct packed {
    logic                hit;
    logic [OFRAME_W-1:0] frame;
    logic                evicted_valid;
    logic [PAGE_W-1:0]   evicted_page;
    logic                fault;
    logic [FCNT_W-1:0]   fault_count;
  } cpr_out_t;

  // Configuration registers as seen by the controller.
  typedef struct packed {
    logic             mode;
    logic [FIU_W-1:0] frames_in_use;
    logic [WA_W-1:0]  write_allowed;
  } cpr_cfg_t;

  // Request bundle towards the page number RAM.
  typedef struct packed {
    logic               we;
    logic [FRAME_W-1:0] waddr;
    logic [PAGE_W-1:0]  wdata;
    logic               re;
    logic [FRAME_W-1:0] raddr;
  } cpr_ram_req_t;

  // Effective frame count: zero acts as one, anything above the table acts as the table.
  function automatic logic [CNT_W-1:0] active_frames(input logic [FIU_W-1:0] fiu);
    logic [CNT_W-1:0] n;
    if (fiu == '0) begin
      n = CNT_W'(1);
    end else if (32'(fiu) > FRAMES) begin
      n = CNT_W'(FRAMES);
    end else begin
      n = CNT_W'(fiu);
    end
    return n;
  endfunction

  // Hand modulo the frame count; the hand is below FRAMES, so a few subtractions do.
  function automatic logic [FRAME_W-1:0] hand_wrap(input logic [FRAME_W-1:0] hand,
                                                   input logic [CNT_W-1:0]   n);
    logic [CNT_W-1:0] a;
    a = CNT_W'(hand);
    for (int i = 0; i < FRAMES - 1; i++) begin
      if (a >= n) begin
        a = a - n;
      end
    end
    return a[FRAME_W-1:0];
  endfunction

  // Per-frame write permission; frames past the register width are never writable.
  function automatic logic [FRAMES-1:0] writable_mask(input logic [WA_W-1:0] wa);
    logic [FRAMES-1:0] m;
    for (int i = 0; i < FRAMES; i++) begin
      m[i] = (i < WA_W) ? wa[i % WA_W] : 1'b0;
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/cpr_page_ram.sv
// Synchronous single-write, single-read RAM holding the resident page number of each frame.
// Generic; no package dependency. Read data is registered.
`timescale 1ns / 1ps

module cpr_page_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 12
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/cpr_engine.sv
// Lookup and replacement controller: walks the page RAM, keeps reference and dirty bits,
// the clock hand, the fill count and the fault counter. Uses cpr_pkg.
`timescale 1ns / 1ps

module cpr_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cpr_pkg::cpr_cfg_t     cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cpr_pkg::cpr_in_t      in_data_i,
  input  logic                  out_free_i,
  output logic                  res_valid_o,
  output cpr_pkg::cpr_out_t     res_o,
  output cpr_pkg::cpr_ram_req_t ram_req_o,
  input  logic [cpr_pkg::PAGE_W-1:0] ram_rdata_i
);

  import cpr_pkg::*;

  cpr_state_e         state_q, state_d;
  logic [PAGE_W-1:0]  page_q, page_d;
  logic               wr_q, wr_d;
  logic [CNT_W-1:0]   look_q, look_d;
  logic               chk_vld_q, chk_vld_d;
  logic [FRAME_W-1:0] chk_idx_q, chk_idx_d;
  logic [FRAME_W-1:0] sel_q, sel_d;
  logic [FRAME_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0]   step_q, step_d;
  logic [1:0]         round_q, round_d;
  logic [FRAMES-1:0]  refb_q, refb_d;
  logic [FRAMES-1:0]  dirty_q, dirty_d;
  logic [FRAME_W-1:0] hand_q, hand_d;
  logic [CNT_W-1:0]   filled_q, filled_d;
  logic [FCNT_W-1:0]  fcnt_q, fcnt_d;

  logic [CNT_W-1:0]   n_frames;
  logic [CNT_W-1:0]   limit;
  logic [FRAMES-1:0]  wmask;
  logic [CNT_W-1:0]   cur_inc;
  logic [FRAME_W-1:0] cur_nxt;
  logic [CNT_W-1:0]   sel_inc;
  logic               page_match;
  logic               scan_match;
  logic               scan_clear;
  logic [1:0]         last_round;

  // Frames that take part in this access: in use and already filled.
  assign n_frames = active_frames(cfg_i.frames_in_use);
  assign limit    = (filled_q < n_frames) ? filled_q : n_frames;
  assign wmask    = writable_mask(cfg_i.write_allowed);

  // Clock neighbours of the scan position and of the chosen frame.
  assign cur_inc = CNT_W'(cur_q) + CNT_W'(1);
  assign cur_nxt = (cur_inc >= n_frames) ? '0 : cur_inc[FRAME_W-1:0];
  assign sel_inc = CNT_W'(sel_q) + CNT_W'(1);

  assign page_match = chk_vld_q && (ram_rdata_i == page_q);

  // Victim test of the current round. The basic clock clears reference bits on its first
  // lap; the enhanced clock looks for (0,0), then (0,1) while clearing, then both again.
  always_comb begin
    if (cfg_i.mode == MODE_ENHANCED) begin
      scan_match = !refb_q[cur_q] && (dirty_q[cur_q] == round_q[0]);
      scan_clear = (round_q == 2'd1);
      last_round = 2'd3;
    end else begin
      scan_match = !refb_q[cur_q];
      scan_clear = (round_q == 2'd0);
      last_round = 2'd1;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state, table updates and the result of a finished access.
  always_comb begin
    state_d   = state_q;
    page_d    = page_q;
    wr_d      = wr_q;
    look_d    = look_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    sel_d     = sel_q;
    cur_d     = cur_q;
    step_d    = step_q;
    round_d   = round_q;
    refb_d    = refb_q;
    dirty_d   = dirty_q;
    hand_d    = hand_q;
    filled_d  = filled_q;
    fcnt_d    = fcnt_q;
    ram_req_o = '0;
    res_valid_o = 1'b0;
    res_o     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          page_d = in_data_i.page;
          wr_d   = in_data_i.is_write;
          look_d = '0;
          state_d = in_data_i.action ? S_CLEAR : S_LOOK;
        end
      end

      // Stream the filled frames out of the RAM and compare one per cycle.
      S_LOOK: begin
        if (page_match) begin
          sel_d   = chk_idx_q;
          state_d = S_HIT;
        end else if (look_q >= limit) begin
          if (filled_q < n_frames) begin
            sel_d   = filled_q[FRAME_W-1:0];
            state_d = S_FILL;
          end else begin
            cur_d   = hand_wrap(hand_q, n_frames);
            step_d  = '0;
            round_d = '0;
            state_d = S_SCAN;
          end
        end else begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = look_q[FRAME_W-1:0];
          chk_vld_d       = 1'b1;
          chk_idx_d       = look_q[FRAME_W-1:0];
          look_d          = look_q + CNT_W'(1);
        end
      end

      S_HIT: begin
        if (out_free_i) begin
          refb_d[sel_q] = 1'b1;
          if (wr_q && wmask[sel_q]) begin
            dirty_d[sel_q] = 1'b1;
          end
          res_valid_o       = 1'b1;
          res_o.hit         = 1'b1;
          res_o.frame       = OFRAME_W'(sel_q);
          res_o.fault_count = fcnt_q;
          state_d           = S_IDLE;
        end
      end

      // A free frame is still available: load it without counting a fault.
      S_FILL: begin
        if (out_free_i) begin
          ram_req_o.we      = 1'b1;
          ram_req_o.waddr   = sel_q;
          ram_req_o.wdata   = page_q;
          refb_d[sel_q]     = 1'b1;
          dirty_d[sel_q]    = 1'b0;
          filled_d          = filled_q + CNT_W'(1);
          res_valid_o       = 1'b1;
          res_o.frame       = OFRAME_W'(sel_q);
          res_o.fault_count = fcnt_q;
          state_d           = S_IDLE;
        end
      end

      S_CLEAR: begin
        if (out_free_i) begin
          refb_d      = '0;
          dirty_d     = '0;
          hand_d      = '0;
          filled_d    = '0;
          fcnt_d      = '0;
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // One frame per cycle around the clock, up to two laps in basic mode and four in enhanced mode.
      S_SCAN: begin
        if (scan_match) begin
          sel_d   = cur_q;
          state_d = S_EVRD;
        end else begin
          if (scan_clear) begin
            refb_d[cur_q] = 1'b0;
          end
          cur_d = cur_nxt;
          if (step_q == n_frames - CNT_W'(1)) begin
            step_d = '0;
            if (round_q == last_round) begin
              sel_d   = '0;
              state_d = S_EVRD;
            end else begin
              round_d = round_q + 2'd1;
            end
          end else begin
            step_d = step_q + CNT_W'(1);
          end
        end
      end

      // Fetch the page that is about to be replaced.
      S_EVRD: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = sel_q;
        state_d         = S_LOAD;
      end

      S_LOAD: begin
        if (out_free_i) begin
          ram_req_o.we        = 1'b1;
          ram_req_o.waddr     = sel_q;
          ram_req_o.wdata     = page_q;
          refb_d[sel_q]       = 1'b1;
          dirty_d[sel_q]      = 1'b0;
          hand_d              = (sel_inc >= n_frames) ? '0 : sel_inc[FRAME_W-1:0];
          if (fcnt_q != FCNT_MAX) begin
            fcnt_d = fcnt_q + FCNT_W'(1);
          end
          res_valid_o         = 1'b1;
          res_o.frame         = OFRAME_W'(sel_q);
          res_o.evicted_valid = (CNT_W'(sel_q) < filled_q);
          res_o.evicted_page  = (CNT_W'(sel_q) < filled_q) ? ram_rdata_i : '0;
          res_o.fault         = 1'b1;
          res_o.fault_count   = (fcnt_q != FCNT_MAX) ? fcnt_q + FCNT_W'(1) : fcnt_q;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      chk_vld_q <= 1'b0;
      refb_q    <= '0;
      dirty_q   <= '0;
      hand_q    <= '0;
      filled_q  <= '0;
      fcnt_q    <= '0;
      look_q    <= '0;
      step_q    <= '0;
      round_q   <= '0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= chk_vld_d;
      refb_q    <= refb_d;
      dirty_q   <= dirty_d;
      hand_q    <= hand_d;
      filled_q  <= filled_d;
      fcnt_q    <= fcnt_d;
      look_q    <= look_d;
      step_q    <= step_d;
      round_q   <= round_d;
    end
  end

  // Working registers of the current access.
  always_ff @(posedge clk_i) begin
    page_q    <= page_d;
    wr_q      <= wr_d;
    chk_idx_q <= chk_idx_d;
    sel_q     <= sel_d;
    cur_q     <= cur_d;
  end

endmodule

>>> hw/rtl/clock_page_replacement_core.sv
// Top level of the clock page replacement core: configuration registers, result register,
// controller and page RAM. Uses cpr_pkg, cpr_engine and cpr_page_ram.
//
//   Port group   Direction  Handshake              Carries
//   in_*         input      in_valid_i/in_stall_o  cpr_in_t: action, page, is_write
//   out_*        output     out_valid_o/out_stall_i cpr_out_t: hit, frame, eviction, fault
//   cfg_*        input      cfg_we_i               mode, frames_in_use, write_allowed
//
// An item is accepted, then the page RAM is read and compared for each filled frame in use,
// and a hit or a fill is committed. A replacement adds the clock scan, one frame per cycle;
// its last lap (the fourth in enhanced mode, the second in basic) can only stop at its first
// frame. One read of the evicted page follows. A clear is accepted and then committed.
// Reset empties the table at once; no clearing pass runs.
// The result register frees the controller; a commit waits only while that register is full
// and stalled, and the next item is accepted as soon as the controller is back in idle.
`timescale 1ns / 1ps

module clock_page_replacement_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cpr_pkg::cpr_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cpr_pkg::cpr_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [cpr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cpr_pkg::CFG_W-1:0]     cfg_wdata_i
);

  import cpr_pkg::*;

  logic             mode_q;
  logic [FIU_W-1:0] fiu_q;
  logic [WA_W-1:0]  wa_q;
  cpr_cfg_t         cfg;

  logic             out_valid_q;
  cpr_out_t         out_data_q;
  logic             out_free;

  logic             res_valid;
  cpr_out_t         res;
  cpr_ram_req_t     ram_req;
  logic [PAGE_W-1:0] ram_rdata;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BASIC;
      fiu_q  <= FIU_RESET;
      wa_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   mode_q <= cfg_wdata_i[0];
        CFG_FRAMES: fiu_q  <= cfg_wdata_i[FIU_W-1:0];
        CFG_WRITE:  wa_q   <= cfg_wdata_i[WA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.mode          = mode_q;
  assign cfg.frames_in_use = fiu_q;
  assign cfg.write_allowed = wa_q;

  // Result register: a new result may be loaded when it is empty or being transferred.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Controller.
  cpr_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Page number store.
  cpr_page_ram #(
    .DEPTH (FRAMES),
    .WIDTH (PAGE_W)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> hw/rtl/cpr_checker.sv
// Port-level checks for the clock page replacement core, attached by the bind below.
// Uses cpr_pkg; sees only the top level's ports.
`timescale 1ns / 1ps

module cpr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_i,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input cpr_pkg::cpr_out_t out_data_i
);

  import cpr_pkg::*;

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or was dropped");

  // Every accepted transfer keeps the controller busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("second transfer taken right after an accepted one");

  // A replacement always evicts a resident page and is never a hit.
  a_fault_evicts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.fault |-> out_data_i.evicted_valid && !out_data_i.hit
      && (out_data_i.fault_count != '0))
    else $error("fault result without eviction or with zero fault count");

  // A hit neither evicts nor faults.
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.hit |-> !out_data_i.evicted_valid && !out_data_i.fault
      && (out_data_i.evicted_page == '0))
    else $error("hit result reports an eviction or a fault");

endmodule

bind clock_page_replacement_core cpr_checker u_cpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
